// ===== src/bta_pkg.sv =====
// ============================================================================
// Bakery ticket arbiter package
// Shared payload types, command and status codes, and the control and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package bta_pkg;

    // Fixed field widths of the external payload.
    localparam int ID_W     = 4;
    localparam int TK_OUT_W = 16;
    localparam int CNT_W    = 5;

    // Command codes.
    localparam logic CMD_TAKE    = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_WAITING   = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic            cmd;
        logic [ID_W-1:0] requester_id;
    } bta_req_t;

    typedef struct packed {
        logic [TK_OUT_W-1:0] assigned_ticket;
        logic                holder_valid;
        logic [ID_W-1:0]     holder_id;
        logic [TK_OUT_W-1:0] holder_ticket;
        logic [1:0]          status;
    } bta_rsp_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;   // latch the request and clear the scan
        logic step;      // read the next ticket entry
        logic commit;    // update the store and load the result
    } bta_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last; // the entry being read is the last active one
        logic n_zero;    // no requester is active
    } bta_sts_t;

endpackage

// ===== src/bta_ctrl.sv =====
// ============================================================================
// Bakery ticket arbiter controller
// Sequences capture, the ticket scan and the final commit of each request.
// ============================================================================
module bta_ctrl
    import bta_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  bta_sts_t sts,
    output bta_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sts.n_zero ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // The result slot must be free or emptying this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_SCAN || state_reg == ST_FINISH))
        else $error("accepted request did not start a scan or finish");

    a_commit_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit did not present a result");

    a_no_commit_over_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit would overwrite a waiting result");
`endif

endmodule

// ===== src/bta_dpath.sv =====
// ============================================================================
// Bakery ticket arbiter datapath
// Ticket store with per-entry valid bits, the scan accumulators and the
// result register.
// ============================================================================
module bta_dpath
    import bta_pkg::*;
#(
    parameter int REQUESTERS  = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [CNT_W-1:0] n_eff,
    input  bta_req_t         s_data,
    input  bta_cmd_t         cmd,
    output bta_sts_t         sts,
    output bta_rsp_t         m_data
);

    localparam int AW = $clog2(REQUESTERS);

    // Ticket store; an entry whose valid bit is clear reads as no ticket.
    logic [TICKET_BITS-1:0] mem [REQUESTERS];
    logic [REQUESTERS-1:0]  vld_reg;

    bta_req_t               req_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    logic [CNT_W-1:0]       sample_idx_reg;
    logic                   sample_vld_reg;
    logic [TICKET_BITS-1:0] rd_data_reg;
    logic                   rd_live_reg;

    logic [TICKET_BITS-1:0] top_reg;
    logic [TICKET_BITS-1:0] own_reg;
    logic                   found_reg;
    logic [CNT_W-1:0]       best_id_reg;
    logic [TICKET_BITS-1:0] best_tk_reg;

    bta_rsp_t               out_reg;
    bta_rsp_t               out_next;

    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [TICKET_BITS-1:0] samp_t;
    logic [TICKET_BITS-1:0] hold_t;
    logic                   is_own;
    logic                   is_release;
    logic                   in_range;
    logic                   take_ok;
    logic [TICKET_BITS-1:0] assigned;

    assign rd_addr    = AW'(scan_idx_reg);
    assign wr_addr    = AW'(req_reg.requester_id);
    assign is_release = (req_reg.cmd == CMD_RELEASE);
    assign in_range   = (CNT_W'(req_reg.requester_id) < n_eff);

    assign sts.scan_last = ((scan_idx_reg + CNT_W'(1)) == n_eff);
    assign sts.n_zero    = (n_eff == '0);

    // Sampled entry; a released entry is seen as empty by the holder search.
    assign samp_t = rd_live_reg ? rd_data_reg : '0;
    assign is_own = (sample_idx_reg == CNT_W'(req_reg.requester_id));
    assign hold_t = (is_release && is_own) ? '0 : samp_t;

    assign take_ok  = in_range && !is_release && (own_reg == '0) && (top_reg != '1);
    assign assigned = top_reg + TICKET_BITS'(1);

    always_comb begin
        out_next                 = '0;
        out_next.holder_valid    = found_reg;
        out_next.holder_id       = found_reg ? ID_W'(best_id_reg) : '0;
        out_next.holder_ticket   = found_reg ? TK_OUT_W'(best_tk_reg) : '0;
        if (!in_range) begin
            out_next.status = STATUS_RANGE;
        end else if (is_release) begin
            out_next.status = STATUS_OK;
        end else if (own_reg != '0) begin
            out_next.status = STATUS_WAITING;
        end else if (top_reg == '1) begin
            out_next.status = STATUS_SATURATED;
        end else begin
            out_next.status          = STATUS_OK;
            out_next.assigned_ticket = TK_OUT_W'(assigned);
            // A new ticket is above every other, so it only wins an empty field.
            if (!found_reg) begin
                out_next.holder_valid  = 1'b1;
                out_next.holder_id     = req_reg.requester_id;
                out_next.holder_ticket = TK_OUT_W'(assigned);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_ok && cmd.commit) begin
            mem[wr_addr] <= assigned;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            sample_vld_reg <= 1'b0;
        end else begin
            sample_vld_reg <= cmd.step;
            if (cmd.commit && take_ok) begin
                vld_reg[wr_addr] <= 1'b1;
            end else if (cmd.commit && in_range && is_release) begin
                vld_reg[wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_live_reg    <= vld_reg[rd_addr];
        sample_idx_reg <= scan_idx_reg;
        if (cmd.capture) begin
            req_reg      <= s_data;
            scan_idx_reg <= '0;
            top_reg      <= '0;
            own_reg      <= '0;
            found_reg    <= 1'b0;
            best_id_reg  <= '0;
            best_tk_reg  <= '0;
        end else begin
            if (cmd.step) begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            if (sample_vld_reg) begin
                if (samp_t > top_reg) begin
                    top_reg <= samp_t;
                end
                if (is_own) begin
                    own_reg <= samp_t;
                end
                if (hold_t != '0 && (!found_reg || hold_t < best_tk_reg)) begin
                    found_reg   <= 1'b1;
                    best_id_reg <= sample_idx_reg;
                    best_tk_reg <= hold_t;
                end
            end
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    a_scan_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (scan_idx_reg < n_eff))
        else $error("scan index beyond the active count");

    a_commit_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !sample_vld_reg)
        else $error("commit while a scan sample is still pending");
`endif

endmodule

// ===== src/bakery_ticket_arbiter_top.sv =====
// ============================================================================
// Bakery ticket arbiter
// Hands out tickets one above the largest held ticket and reports the holder
// with the smallest ticket after every request.
// ============================================================================
//
// Channel   Direction  Ports                             Carries
// s_        in         s_valid, s_ready, s_data          take or release request
// m_        out        m_valid, m_ready, m_data          ticket, holder and status
// cfg_      in         cfg_wr_en, cfg_wr_data            active requester count
//
// A request runs through these steps from its offer to its result, where n is
// the active count limited to REQUESTERS: the accept, n reads of the single
// read port walking the ticket store, a drain of the read pipeline and the
// commit. A count of zero skips both the scan and the drain. Reset clears
// every ticket through per-entry valid bits, so no clearing pass is needed.
// A result waits in the output register while the next request is accepted
// and scanned; only the commit stalls on it.
//
module bakery_ticket_arbiter_top
    import bta_pkg::*;
#(
    parameter int REQUESTERS  = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  bta_req_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output bta_rsp_t         m_data
);

    // The count register resets to sixteen requesters.
    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

    logic [CNT_W-1:0] active_count_reg;
    logic [CNT_W-1:0] n_eff;
    bta_cmd_t         cmd;
    bta_sts_t         sts;

    // The count register is to be written only between requests, so the scan
    // sees a stable value for the whole of each request; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_count_reg <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            active_count_reg <= cfg_wr_data;
        end
    end

    // Counts above the number of implemented requesters are limited to it.
    assign n_eff = (32'(active_count_reg) > REQUESTERS) ? CNT_W'(REQUESTERS)
                                                        : active_count_reg;

    bta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bta_dpath #(
        .REQUESTERS  (REQUESTERS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .n_eff   (n_eff),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ===== test/testbench.sv =====
// ============================================================================
// Bakery ticket arbiter testbench
// Drives take and release requests through the valid/ready channels and
// checks every result, field by field, against a ticket-store predictor
// kept in step with the block. A short table of requests comes first, then
// random requests under several active counts and idling patterns.
// ============================================================================
`timescale 1ns / 100ps

module testbench;

    import bta_pkg::*;

    // The block is tested at its default sizes.
    localparam int REQUESTERS  = 16;
    localparam int TICKET_BITS = 16;

    localparam int PERIOD      = 20;
    localparam int RESET_HOLD  = 11;
    // This margin covers a request at the full count.
    localparam int DRAIN_GAP   = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 138;
    localparam int CYCLE_LIMIT = 200_000;

    localparam logic [TICKET_BITS-1:0] TICKET_TOP = '1;

    // Kinds of row in the directed table.
    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_CONFIG
    } row_kind_e;

    // One row of the directed table. Where typed is set, rsp holds the result
    // written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        row_kind_e        kind;
        bta_req_t         req;
        logic [CNT_W-1:0] count;
        logic             typed;
        bta_rsp_t         rsp;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input starts at a known
    // value so that nothing floats before the first falling edge.
    // ------------------------------------------------------------------------
    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    bta_req_t         s_data      = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    bta_rsp_t         m_data;

    always #(PERIOD / 2) aclk = ~aclk;

    bakery_ticket_arbiter_top #(
        .REQUESTERS  (REQUESTERS),
        .TICKET_BITS (TICKET_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: our own copy of the ticket store and the active count.
    // It is advanced once for every request that the block accepts, in the
    // order of acceptance, so it always matches what the block should hold.
    // ------------------------------------------------------------------------
    logic [TICKET_BITS-1:0] tickets [REQUESTERS];
    logic [CNT_W-1:0]       active_cnt;

    // Results still owed by the block, oldest first.
    bta_rsp_t due[$];

    int mismatches  = 0;
    int cycle_count = 0;

    // Idling controls, set by the main sequence and read by the driver and
    // by the receiver process. Percentages are per cycle.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // A long receiver hold-off is asked for by bumping hold_asks; the receiver
    // process notices the change and counts the stretch down itself.
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // Applies one request to the predictor state and returns the result that
    // the block must report for it. The effective count is the register
    // saturated at the number of requesters; entries above it keep their
    // tickets but are invisible to both the maximum and the holder search.
    function automatic bta_rsp_t arbitrate(input bta_req_t req);
        bta_rsp_t               res;
        int                     n;
        logic [TICKET_BITS-1:0] top;
        logic [TICKET_BITS-1:0] best;
        res        = '0;
        res.status = STATUS_OK;
        best       = '0;
        n          = (active_cnt > REQUESTERS) ? REQUESTERS : int'(active_cnt);
        if (int'(req.requester_id) >= n) begin
            res.status = STATUS_RANGE;
        end else if (req.cmd == CMD_RELEASE) begin
            tickets[req.requester_id] = '0;
        end else if (tickets[req.requester_id] != '0) begin
            res.status = STATUS_WAITING;
        end else begin
            top = '0;
            for (int i = 0; i < n; i++) begin
                if (tickets[i] > top) begin
                    top = tickets[i];
                end
            end
            if (top == TICKET_TOP) begin
                res.status = STATUS_SATURATED;
            end else begin
                tickets[req.requester_id] = top + 1'b1;
                res.assigned_ticket       = top + 1'b1;
            end
        end
        // Smallest nonzero ticket wins; the strict comparison keeps the lower
        // index on a tie.
        for (int i = 0; i < n; i++) begin
            if (tickets[i] != '0 && (!res.holder_valid || tickets[i] < best)) begin
                res.holder_valid  = 1'b1;
                res.holder_id     = ID_W'(i);
                best              = tickets[i];
                res.holder_ticket = tickets[i];
            end
        end
        return res;
    endfunction

    function automatic bta_req_t request(input logic cmd, input int id);
        bta_req_t req;
        req.cmd          = cmd;
        req.requester_id = ID_W'(id);
        return req;
    endfunction

    function automatic bta_rsp_t outcome(input int assigned, input logic valid,
                                         input int id, input int tk,
                                         input logic [1:0] st);
        bta_rsp_t res;
        res.assigned_ticket = TK_OUT_W'(assigned);
        res.holder_valid    = valid;
        res.holder_id       = ID_W'(id);
        res.holder_ticket   = TK_OUT_W'(tk);
        res.status          = st;
        return res;
    endfunction

    function automatic plan_row_t plan_row(input row_kind_e kind, input logic cmd,
                                           input int id, input int count,
                                           input logic typed, input bta_rsp_t rsp);
        plan_row_t row;
        row.kind  = kind;
        row.req   = request(cmd, id);
        row.count = CNT_W'(count);
        row.typed = typed;
        row.rsp   = rsp;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. It is entered at a falling edge and returns at the
    // falling edge after acceptance with valid still high, so that the next
    // request follows without a bubble. Idle gaps are drawn before valid goes
    // up, never while a request is on offer.
    // ------------------------------------------------------------------------
    task automatic send(input bta_req_t req, input logic typed, input bta_rsp_t rsp);
        bta_rsp_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = arbitrate(req);
        due.push_back(typed ? rsp : predicted);
        @(negedge aclk);
    endtask

    // Withdraws valid and waits until every owed result has been taken, then
    // lets the pipeline run dry before anything touches the register.
    task automatic settle();
        s_valid <= 1'b0;
        while (due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_GAP) @(negedge aclk);
    endtask

    // Register write: one cycle of write enable, applied while the block idles.
    task automatic write_count(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        active_cnt   = CNT_W'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic compare_field(input string name, input longint want,
                                 input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. m_ready changes only at the falling edge. A requested
    // hold-off keeps it low for a long stretch regardless of the stall rate,
    // which lets the block fill and push back on the request side.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker. Each result taken at a rising edge is compared with the
    // oldest owed result, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        bta_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due.size() == 0) begin
                $display("%0t: result %h arrived with nothing outstanding", $time, m_data);
                mismatches++;
            end else begin
                want = due.pop_front();
                compare_field("assigned_ticket", want.assigned_ticket,
                              m_data.assigned_ticket);
                compare_field("holder_valid", want.holder_valid, m_data.holder_valid);
                compare_field("holder_id", want.holder_id, m_data.holder_id);
                compare_field("holder_ticket", want.holder_ticket, m_data.holder_ticket);
                compare_field("status", want.status, m_data.status);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : main_sequence
        plan_row_t plan[$];
        int        phase_count [8];
        int        n;
        int        waited;
        logic      cmd;
        int        id;

        foreach (tickets[i]) begin
            tickets[i] = '0;
        end
        active_cnt = 16;

        // The directed table. Results are typed in only where they follow
        // at once from the request; the rest come from the predictor.
        // Releasing a ticket that was never taken changes nothing.
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 0, 0, 1'b1,
                                outcome(0, 1'b0, 0, 0, STATUS_OK)));
        // The first ticket from an empty store is 1; the top index may take it.
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 15, 0, 1'b1,
                                outcome(1, 1'b1, 15, 1, STATUS_OK)));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 0, 0, 1'b1,
                                outcome(2, 1'b1, 15, 1, STATUS_OK)));
        // A second take while still waiting is refused.
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 15, 0, 1'b1,
                                outcome(0, 1'b1, 15, 1, STATUS_WAITING)));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 7, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 15, 0, 1'b0, '0));
        // Shrinking the count puts the upper indexes out of range.
        plan.push_back(plan_row(ROW_CONFIG, CMD_TAKE, 0, 8, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 8, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 15, 0, 1'b0, '0));
        // A count of zero flags everything and hides every holder.
        plan.push_back(plan_row(ROW_CONFIG, CMD_TAKE, 0, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 0, 0, 1'b1,
                                outcome(0, 1'b0, 0, 0, STATUS_RANGE)));
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 0, 0, 1'b1,
                                outcome(0, 1'b0, 0, 0, STATUS_RANGE)));
        // With one requester active, the hidden tickets must not raise the
        // next ticket.
        plan.push_back(plan_row(ROW_CONFIG, CMD_TAKE, 0, 1, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 0, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 0, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 0, 0, 1'b1,
                                outcome(1, 1'b1, 0, 1, STATUS_OK)));
        // A count above the requester total saturates, and the hidden
        // tickets count again.
        plan.push_back(plan_row(ROW_CONFIG, CMD_TAKE, 0, 31, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 9, 0, 1'b0, '0));
        // Back to two requesters: the tickets of the others drop out again.
        plan.push_back(plan_row(ROW_CONFIG, CMD_TAKE, 0, 2, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_TAKE, 1, 0, 1'b0, '0));
        plan.push_back(plan_row(ROW_REQUEST, CMD_RELEASE, 0, 0, 1'b0, '0));

        // Active counts for the random phases, extremes among them.
        phase_count = '{16, 4, 1, 31, 9, 16, 2, 13};

        // Reset is held for a fixed stretch once, at the start, and released
        // at a falling edge like every other input.
        repeat (RESET_HOLD) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[k]) begin
            case (plan[k].kind)
                ROW_REQUEST: begin
                    send(plan[k].req, plan[k].typed, plan[k].rsp);
                end
                ROW_CONFIG: begin
                    settle();
                    write_count(plan[k].count);
                end
                default: begin
                end
            endcase
        end

        // Random phases. Each one starts from an idle block with a fresh
        // active count and cycles through the four idling patterns. Most
        // requests name an active requester, so tickets pile up and the
        // holder moves; a few name any index to hit the range check.
        for (int p = 0; p < 8; p++) begin
            settle();
            write_count(phase_count[p]);
            case (p % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 60;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 60;
                end
                default: begin
                    src_idle_pct  = 30;
                    snk_stall_pct = 30;
                end
            endcase
            // Long receiver hold-offs while requests keep coming.
            if (p == 0 || p == 5) begin
                hold_asks++;
            end
            n = (phase_count[p] > REQUESTERS) ? REQUESTERS : phase_count[p];
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                cmd = ($urandom_range(0, 99) < 45) ? CMD_RELEASE : CMD_TAKE;
                if (n == 0 || $urandom_range(0, 99) < 8) begin
                    id = $urandom_range(0, REQUESTERS - 1);
                end else begin
                    id = $urandom_range(0, n - 1);
                end
                send(request(cmd, id), 1'b0, '0);
            end
        end

        // Wind down: collect what is owed, then watch a little longer for
        // anything stray.
        s_valid <= 1'b0;
        waited = 0;
        while (due.size() != 0 && waited < 20000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (DRAIN_GAP) @(negedge aclk);
        if (due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, due.size());
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
